FILE: sv/sli_pkg.sv
// Shared types and codes of the sequential list insert and delete block.
package sli_pkg;

    // Operation codes carried on the op field of a request.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Status codes carried on the status field of a result.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Width of the public fields.
    localparam int unsigned OP_W     = 2;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned PORT_W   = 32;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned STATUS_W = 2;

    // Control state of the sequencer.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    // Commands broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic ins;      // shift up above the point and write the word at the point
        logic del;      // shift down from the point upwards
        logic rd_load;  // copy the entries into the read-out chain
        logic rd_shift; // move the read-out chain one place towards cell zero
    } t_cell_cmd;

endpackage

FILE: sv/sequential_list_insert_delete.sv
// Top level of the sequential list insert and delete block: sequencer and row of cells.
//
// A request is taken at a rising edge with start high and busy low. It carries op
// (insert, get, delete, clear), a signed position and a data word for insert.
// Every request gives exactly one result, shown for one cycle with o_done high,
// carrying the status, the word read and the number of entries afterwards.
// The receiver cannot stall; a result is simply taken in the cycle it is shown.
// Insert, clear and any rejected request give their result in the cycle after the
// request and leave busy low, so such requests may follow every cycle.
// A valid get or delete snapshots the row into a read-out chain, which moves one
// place towards cell zero per cycle; busy stays high from the request until the
// word at the position reaches cell zero, and drops as the result is shown.
// The capacity register is written through i_cfg_valid / o_cfg_ready, which is
// always ready; the user must write it only while the block is idle, as the
// block itself does not enforce this.
// A synchronous reset empties the list and sets the capacity to 64; the entries
// themselves are not cleared, since only written positions can ever be read.
module sequential_list_insert_delete #(
    parameter int unsigned DEPTH     = 64,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sli_pkg::OP_W-1:0]            i_op,
    input  logic signed [sli_pkg::POS_W-1:0]    i_position,
    input  logic [sli_pkg::PORT_W-1:0]          i_entry_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sli_pkg::COUNT_W-1:0]         i_cfg_data,
    output logic                                o_done,
    output logic [sli_pkg::STATUS_W-1:0]        o_status,
    output logic [sli_pkg::PORT_W-1:0]          o_read_word,
    output logic [sli_pkg::COUNT_W-1:0]         o_count_now
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned MW = (CW > sli_pkg::COUNT_W) ? CW : sli_pkg::COUNT_W;
    localparam logic [sli_pkg::COUNT_W-1:0] CAP_RESET = 7'd64;
    localparam logic [MW-1:0] DEPTH_MW = MW'(DEPTH);

    sli_pkg::t_state r_state;
    sli_pkg::t_state n_state;
    logic [CW-1:0]   r_fill;
    logic [CW-1:0]   n_fill;
    logic [CW-1:0]   r_left;
    logic [CW-1:0]   n_left;
    logic [sli_pkg::COUNT_W-1:0] r_cap;
    logic            r_done;
    logic            n_done;
    logic [sli_pkg::STATUS_W-1:0] r_status;
    logic [sli_pkg::STATUS_W-1:0] n_status;
    logic [sli_pkg::PORT_W-1:0]   r_word;
    logic [sli_pkg::PORT_W-1:0]   n_word;
    logic [sli_pkg::COUNT_W-1:0]  r_count;
    logic [sli_pkg::COUNT_W-1:0]  n_count;

    logic                 w_accept;
    logic                 w_neg;
    logic [MW-1:0]        w_pos;
    logic [MW-1:0]        w_fill;
    logic [MW-1:0]        w_cap;
    logic [MW-1:0]        w_limit;
    logic                 w_full;
    logic                 w_ins_ok;
    logic                 w_rd_ok;
    logic [MW-1:0]        w_point_mw;
    logic [CW-1:0]        w_point;
    logic [CW-1:0]        w_fill_up;
    logic [CW-1:0]        w_fill_dn;
    logic [63:0]          w_in64;
    logic [WORD_BITS-1:0] w_word;
    logic [63:0]          w_rd64;
    sli_pkg::t_cell_cmd   w_cmd;

    logic [WORD_BITS-1:0] w_entry [DEPTH];
    logic [WORD_BITS-1:0] w_rc    [DEPTH];

    // Decode of the request against the current fill and capacity.
    assign w_accept  = start && !busy;
    assign w_neg     = i_position[sli_pkg::POS_W-1];
    assign w_pos     = MW'(i_position[sli_pkg::POS_W-2:0]);
    assign w_fill    = MW'(r_fill);
    assign w_cap     = MW'(r_cap);
    assign w_limit   = (w_cap > DEPTH_MW) ? DEPTH_MW : w_cap;
    assign w_full    = (w_fill >= w_limit);
    assign w_ins_ok  = (i_op == sli_pkg::OP_INSERT) && !w_neg && !w_full;
    assign w_rd_ok   = ((i_op == sli_pkg::OP_GET) || (i_op == sli_pkg::OP_DELETE))
                       && !w_neg && (w_pos < w_fill);
    assign w_fill_up = CW'(r_fill + CW'(1));
    assign w_fill_dn = CW'(r_fill - CW'(1));

    // An insert past the end is clamped to an append; both fit the cell index width.
    assign w_point_mw = ((i_op == sli_pkg::OP_INSERT) && (w_pos > w_fill)) ? w_fill : w_pos;
    assign w_point    = w_point_mw[CW-1:0];

    // Word width conversion between the ports and the cells.
    assign w_in64 = 64'(i_entry_word);
    assign w_word = w_in64[WORD_BITS-1:0];
    assign w_rd64 = 64'(w_rc[0]);

    // Commands to the row of cells.
    always_comb begin
        w_cmd.ins      = w_accept && w_ins_ok;
        w_cmd.del      = w_accept && w_rd_ok && (i_op == sli_pkg::OP_DELETE);
        w_cmd.rd_load  = w_accept && w_rd_ok;
        w_cmd.rd_shift = (r_state == sli_pkg::S_SCAN) && (r_left != '0);
    end

    // Row of cells, each linked to its two neighbours.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] w_left_entry;
        logic [WORD_BITS-1:0] w_right_entry;
        logic [WORD_BITS-1:0] w_right_rc;

        if (g == 0) begin : g_first
            assign w_left_entry = '0;
        end else begin : g_inner_l
            assign w_left_entry = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_entry = '0;
            assign w_right_rc    = '0;
        end else begin : g_inner_r
            assign w_right_entry = w_entry[g+1];
            assign w_right_rc    = w_rc[g+1];
        end

        sli_cell #(
            .WORD_BITS (WORD_BITS),
            .CW        (CW),
            .IDX       (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_point       (w_point),
            .i_word        (w_word),
            .i_left_entry  (w_left_entry),
            .i_right_entry (w_right_entry),
            .i_right_rc    (w_right_rc),
            .o_entry       (w_entry[g]),
            .o_rc          (w_rc[g])
        );
    end

    // Sequencer: result of a short request, or the walk of the read-out chain.
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_left   = r_left;
        n_done   = 1'b0;
        n_status = r_status;
        n_word   = r_word;
        n_count  = r_count;
        unique case (r_state)
            sli_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_word = '0;
                    unique case (i_op)
                        sli_pkg::OP_INSERT: begin
                            n_done = 1'b1;
                            if (w_neg) begin
                                n_status = sli_pkg::ST_BAD_POS;
                            end else if (w_full) begin
                                n_status = sli_pkg::ST_FULL;
                            end else begin
                                n_status = sli_pkg::ST_OK;
                                n_fill   = w_fill_up;
                            end
                        end
                        sli_pkg::OP_GET, sli_pkg::OP_DELETE: begin
                            if (w_rd_ok) begin
                                n_state  = sli_pkg::S_SCAN;
                                n_left   = w_point;
                                n_status = sli_pkg::ST_OK;
                                if (i_op == sli_pkg::OP_DELETE) begin
                                    n_fill = w_fill_dn;
                                end
                            end else begin
                                n_done   = 1'b1;
                                n_status = sli_pkg::ST_BAD_POS;
                            end
                        end
                        sli_pkg::OP_CLEAR: begin
                            n_done   = 1'b1;
                            n_status = sli_pkg::ST_OK;
                            n_fill   = '0;
                        end
                        default: begin
                            n_done = 1'b0;
                        end
                    endcase
                    n_count = MW'(n_fill) >> 0 == '0 ? '0 : 7'(MW'(n_fill));
                end
            end
            sli_pkg::S_SCAN: begin
                if (r_left == '0) begin
                    n_done  = 1'b1;
                    n_word  = w_rd64[sli_pkg::PORT_W-1:0];
                    n_state = sli_pkg::S_IDLE;
                end else begin
                    n_left = CW'(r_left - CW'(1));
                end
            end
            default: begin
                n_state = sli_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sli_pkg::S_IDLE;
            r_fill  <= '0;
            r_cap   <= CAP_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // Result payload and scan counter need no reset.
    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_status <= n_status;
        r_word   <= n_word;
        r_count  <= n_count;
    end

    assign busy        = (r_state != sli_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_read_word = r_word;
    assign o_count_now = r_count;

endmodule

FILE: sv/sli_cell.sv
// One list position: an entry register and one stage of the read-out chain.
module sli_cell #(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned CW        = 7,
    parameter int unsigned IDX       = 0
) (
    input  logic                  i_clk,
    input  sli_pkg::t_cell_cmd    i_cmd,
    input  logic [CW-1:0]         i_point,
    input  logic [WORD_BITS-1:0]  i_word,
    input  logic [WORD_BITS-1:0]  i_left_entry,
    input  logic [WORD_BITS-1:0]  i_right_entry,
    input  logic [WORD_BITS-1:0]  i_right_rc,
    output logic [WORD_BITS-1:0]  o_entry,
    output logic [WORD_BITS-1:0]  o_rc
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [WORD_BITS-1:0] r_entry;
    logic [WORD_BITS-1:0] n_entry;
    logic [WORD_BITS-1:0] r_rc;
    logic [WORD_BITS-1:0] n_rc;

    // Entry update: take the lower neighbour on insert, the upper one on delete.
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (MY_IDX > i_point) begin
                n_entry = i_left_entry;
            end else if (MY_IDX == i_point) begin
                n_entry = i_word;
            end
        end else if (i_cmd.del) begin
            if (MY_IDX >= i_point) begin
                n_entry = i_right_entry;
            end
        end
    end

    // Read-out chain: a snapshot of the entry that walks towards cell zero.
    always_comb begin
        n_rc = r_rc;
        if (i_cmd.rd_load) begin
            n_rc = r_entry;
        end else if (i_cmd.rd_shift) begin
            n_rc = i_right_rc;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_rc    <= n_rc;
    end

    assign o_entry = r_entry;
    assign o_rc    = r_rc;

endmodule

FILE: sv/sli_checker.sv
// Port-level checker of the sequential list insert and delete block, with its bind.
module sli_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic [sli_pkg::OP_W-1:0]         i_op,
    input logic                             o_done,
    input logic [sli_pkg::STATUS_W-1:0]     o_status,
    input logic [sli_pkg::PORT_W-1:0]       o_read_word,
    input logic [sli_pkg::COUNT_W-1:0]      o_count_now
);

    // A taken request either answers at once or holds the block busy.
    a_req_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("request neither answered nor in progress");

    // A result is only ever shown once the block is idle again.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // A rejected request returns no data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != sli_pkg::ST_OK)) |-> (o_read_word == '0))
        else $error("rejected request returned data");

    // Status is never the unused code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_status == sli_pkg::ST_OK) || (o_status == sli_pkg::ST_BAD_POS)
                    || (o_status == sli_pkg::ST_FULL)))
        else $error("undefined status code");

    // A clear answers in the next cycle with an empty list.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == sli_pkg::OP_CLEAR)) |=>
        (o_done && (o_status == sli_pkg::ST_OK) && (o_count_now == '0)
         && (o_read_word == '0)))
        else $error("clear did not empty the list");

endmodule

bind sequential_list_insert_delete sli_checker u_sli_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_op        (i_op),
    .o_done      (o_done),
    .o_status    (o_status),
    .o_read_word (o_read_word),
    .o_count_now (o_count_now)
);

FILE: verif/sli_list_checker.sv
// Checker for the positional list block: follows both channels, predicts each result and compares.
module sli_list_checker #(
    parameter int unsigned LIST_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [sli_pkg::OP_W-1:0]            i_op,
    input  logic signed [sli_pkg::POS_W-1:0]    i_position,
    input  logic [sli_pkg::PORT_W-1:0]          i_entry_word,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [sli_pkg::COUNT_W-1:0]         i_cfg_data,
    input  logic                                i_done,
    input  logic [sli_pkg::STATUS_W-1:0]        i_status,
    input  logic [sli_pkg::PORT_W-1:0]          i_read_word,
    input  logic [sli_pkg::COUNT_W-1:0]         i_count_now,
    output int                                  o_mismatches,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted result of a request.
    typedef struct packed {
        logic [sli_pkg::STATUS_W-1:0] status;
        logic [sli_pkg::PORT_W-1:0]   word;
        logic [sli_pkg::COUNT_W-1:0]  count;
    } t_list_result;

    // Private copy of the list contents, its fill and the capacity register.
    logic [sli_pkg::PORT_W-1:0]  list_words [0:LIST_DEPTH-1];
    int unsigned                 list_fill = 0;
    logic [sli_pkg::COUNT_W-1:0] list_cap  = 7'd64;

    t_list_result pending_results [$];
    int           mismatch_total = 0;

    // Applies one request to the private list and returns the result it should give.
    function automatic t_list_result apply_list_op(
        input logic [sli_pkg::OP_W-1:0]          op,
        input logic signed [sli_pkg::POS_W-1:0]  pos,
        input logic [sli_pkg::PORT_W-1:0]        word
    );
        t_list_result res;
        int unsigned  slot;
        int unsigned  cap_eff;
        int unsigned  k;
        res.status = sli_pkg::ST_OK;
        res.word   = '0;
        cap_eff    = (list_cap > LIST_DEPTH) ? LIST_DEPTH : list_cap;
        slot       = pos[sli_pkg::POS_W-2:0];
        case (op)
            sli_pkg::OP_INSERT: begin
                // A negative position is rejected before fullness is looked at.
                if (pos[sli_pkg::POS_W-1]) begin
                    res.status = sli_pkg::ST_BAD_POS;
                end else if (list_fill >= cap_eff) begin
                    res.status = sli_pkg::ST_FULL;
                end else begin
                    if (slot > list_fill) begin
                        slot = list_fill;
                    end
                    for (k = list_fill; k > slot; k--) begin
                        list_words[k] = list_words[k-1];
                    end
                    list_words[slot] = word;
                    list_fill++;
                end
            end
            sli_pkg::OP_GET, sli_pkg::OP_DELETE: begin
                if (pos[sli_pkg::POS_W-1] || slot >= list_fill) begin
                    res.status = sli_pkg::ST_BAD_POS;
                end else begin
                    res.word = list_words[slot];
                    if (op == sli_pkg::OP_DELETE) begin
                        for (k = slot; k + 1 < list_fill; k++) begin
                            list_words[k] = list_words[k+1];
                        end
                        list_fill--;
                    end
                end
            end
            default: begin
                list_fill = 0;
            end
        endcase
        res.count = list_fill[sli_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // Counts a failure and reports the first few of them.
    task automatic note_mismatch(input string what, input t_list_result want);
        mismatch_total++;
        if (mismatch_total <= 10) begin
            $write("%0t: %s: expected status %0d word %h count %0d",
                   $realtime, what, want.status, want.word, want.count);
            $display(", got status %0d word %h count %0d",
                     i_status, i_read_word, i_count_now);
        end
    endtask

    // Results are taken before new requests, since a result never belongs to the
    // request accepted at the same edge.
    always @(posedge i_clk) begin : watch
        t_list_result want;
        if (!i_rst_n) begin
            list_fill = 0;
            list_cap  = 7'd64;
            pending_results.delete();
        end else begin
            if (i_done) begin
                if (pending_results.size() == 0) begin
                    want = '0;
                    note_mismatch("result with no request waiting", want);
                end else begin
                    want = pending_results.pop_front();
                    if (want.status !== i_status || want.word !== i_read_word ||
                        want.count !== i_count_now) begin
                        note_mismatch("result mismatch", want);
                    end
                end
            end
            if (i_start && !i_busy) begin
                pending_results.push_back(apply_list_op(i_op, i_position, i_entry_word));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                list_cap = i_cfg_data;
            end
        end
        o_mismatches <= mismatch_total;
        o_pending    <= pending_results.size();
    end

endmodule

FILE: verif/tb_sequential_list_insert_delete.sv
// Testbench top of the positional list block: clock, reset, request stimulus and verdict.
module tb_sequential_list_insert_delete;
    timeunit 1ns;
    timeprecision 1ps;

    import sli_pkg::*;

    localparam int unsigned LIST_DEPTH  = 64;
    localparam int          PHASE_ITEMS = 128;
    localparam int          TAIL_CYCLES = LIST_DEPTH + 8;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       start        = 1'b0;
    logic                       busy;
    logic [OP_W-1:0]            i_op         = OP_INSERT;
    logic signed [POS_W-1:0]    i_position   = '0;
    logic [PORT_W-1:0]          i_entry_word = '0;
    logic                       i_cfg_valid  = 1'b0;
    logic                       o_cfg_ready;
    logic [COUNT_W-1:0]         i_cfg_data   = '0;
    logic                       o_done;
    logic [STATUS_W-1:0]        o_status;
    logic [PORT_W-1:0]          o_read_word;
    logic [COUNT_W-1:0]         o_count_now;

    int                         mismatches;
    int                         pending;
    logic [COUNT_W-1:0]         seen_count   = '0;
    int                         phase_caps [12] = '{64, 1, 127, 0, 2, 40, 64, 70, 5, 63, 0, 64};

    sequential_list_insert_delete #(
        .DEPTH     (LIST_DEPTH),
        .WORD_BITS (PORT_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_entry_word (i_entry_word),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_read_word  (o_read_word),
        .o_count_now  (o_count_now)
    );

    sli_list_checker #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_entry_word (i_entry_word),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_done       (o_done),
        .i_status     (o_status),
        .i_read_word  (o_read_word),
        .i_count_now  (o_count_now),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Free-running clock.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard limit on the length of the run.
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // The last count reported steers positions and the choice of operations.
    always @(posedge i_clk) begin
        if (o_done) begin
            seen_count <= o_count_now;
        end
    end

    // Presents one request and holds it until the block takes it.
    task automatic send_request(input logic [OP_W-1:0] op, input logic signed [POS_W-1:0] pos,
                                input logic [PORT_W-1:0] word);
        start        <= 1'b1;
        i_op         <= op;
        i_position   <= pos;
        i_entry_word <= word;
        do @(posedge i_clk); while (busy);
    endtask

    // Random pause between requests: mostly none or short, now and then long.
    task automatic idle_gap();
        int roll;
        int len;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            len = 0;
        end else if (roll < 90) begin
            len = $urandom_range(1, 3);
        end else if (roll < 98) begin
            len = $urandom_range(4, 15);
        end else begin
            len = $urandom_range(20, 60);
        end
        if (len > 0) begin
            start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    // Stops sending until every outstanding request has given its result.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Writes the capacity register; only called while the block is idle.
    task automatic write_capacity(input logic [COUNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // One random phase at a given capacity, alternating between filling and draining.
    task automatic run_phase(input int cap_value);
        bit                     growing;
        bit                     no_gaps;
        int                     roll;
        int                     cap_eff;
        logic [OP_W-1:0]        op;
        logic signed [POS_W-1:0] pos;
        wait_drained();
        write_capacity(COUNT_W'(cap_value));
        cap_eff = (cap_value > LIST_DEPTH) ? LIST_DEPTH : cap_value;
        growing = (seen_count < cap_eff);
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Turn round at the ends, lingering a while at full so inserts are refused.
            if (growing && seen_count >= cap_eff && $urandom_range(0, 3) == 0) begin
                growing = 1'b0;
            end else if (!growing && seen_count == 0) begin
                growing = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (growing) begin
                op = (roll < 62) ? OP_INSERT : (roll < 80) ? OP_GET :
                     (roll < 98) ? OP_DELETE : OP_CLEAR;
            end else begin
                op = (roll < 20) ? OP_INSERT : (roll < 40) ? OP_GET :
                     (roll < 98) ? OP_DELETE : OP_CLEAR;
            end
            // Mostly positions in or just past the list, the rest anywhere, negatives too.
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                pos = POS_W'($urandom_range(0, seen_count));
            end else if (roll < 85) begin
                pos = POS_W'($urandom_range(0, 127));
            end else begin
                pos = POS_W'($urandom);
            end
            send_request(op, pos, $urandom);
            if (!no_gaps) begin
                idle_gap();
            end
            if ($urandom_range(0, 49) == 0) begin
                wait_drained();
            end
        end
    endtask

    // Reset, directed requests, random phases, then the verdict.
    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_capacity(7'd64);

        // Empty list, negative positions, clamped and ordinary inserts.
        send_request(OP_GET, 0, 32'h0);
        send_request(OP_DELETE, 0, 32'h0);
        send_request(OP_INSERT, -1, 32'h1111_1111);
        send_request(OP_INSERT, -128, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 127, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 0, 32'h0000_0000);
        send_request(OP_INSERT, 1, 32'hA5A5_A5A5);
        send_request(OP_INSERT, 100, 32'h5A5A_5A5A);
        send_request(OP_GET, 0, 32'h0);
        send_request(OP_GET, 3, 32'h0);
        send_request(OP_GET, 4, 32'h0);
        send_request(OP_GET, 127, 32'h0);
        send_request(OP_GET, -1, 32'h0);
        send_request(OP_DELETE, 1, 32'h0);
        send_request(OP_DELETE, 2, 32'h0);
        send_request(OP_DELETE, -128, 32'h0);
        send_request(OP_CLEAR, 0, 32'h0);
        send_request(OP_GET, 0, 32'h0);

        // Capacity of one: full list, and a negative position when full.
        wait_drained();
        write_capacity(7'd1);
        send_request(OP_INSERT, 0, $urandom);
        send_request(OP_INSERT, 5, $urandom);
        send_request(OP_INSERT, -1, $urandom);

        // Capacity zero, lowered below the fill: entries stay readable.
        wait_drained();
        write_capacity(7'd0);
        send_request(OP_INSERT, 0, $urandom);
        send_request(OP_GET, 0, 32'h0);
        send_request(OP_DELETE, 0, 32'h0);
        send_request(OP_INSERT, 0, $urandom);

        phase_caps[10] = $urandom_range(0, 127);
        foreach (phase_caps[p]) begin
            run_phase(phase_caps[p]);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
